// ===== sv/wfmw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfmw_pkg;

   localparam int MODE_W   = 2;
   localparam int COORD_W  = 7;
   localparam int PIDX_W   = 14;
   localparam int LEN_W    = 14;
   localparam int CNT_W    = LEN_W + 1;
   localparam int GRID_W   = 8;
   localparam int NSIZE_W  = GRID_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 14;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [1:0]        dir_type;

   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_WALK  = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   localparam dir_type DIR_N = 2'd0;
   localparam dir_type DIR_W = 2'd1;
   localparam dir_type DIR_S = 2'd2;
   localparam dir_type DIR_E = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_LIMIT = 1'd1;

   localparam logic [GRID_W-1:0] GRID_SIZE_RESET  = 8'd128;
   localparam logic [LEN_W-1:0]  MOVE_LIMIT_RESET = 14'd10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREAD,
      ST_END,
      ST_LEFT,
      ST_TRY,
      ST_MOVE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== sv/wall_follower_maze_walk_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cell write: ST_RESP, then the output register. Path read: ST_PREAD, ST_RESP,
// then the output register. Walk: per move the end check, the left check and up
// to three right turns, each behind the registered cell store read of its neighbor.
// One request is worked at a time; the next is taken while a result waits.
// Reset clears control, path length, grid_size (128) and move_limit (10000);
// cell and path stores are not cleared.
module wall_follower_maze_walk_top #(
   parameter int GRID_SIDE  = 128,
   parameter int PATH_DEPTH = 16384
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [wfmw_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [wfmw_pkg::COORD_W-1:0]       req_row,
   input  wire logic [wfmw_pkg::COORD_W-1:0]       req_col,
   input  wire logic                               req_wall,
   input  wire logic [wfmw_pkg::COORD_W-1:0]       req_end_row,
   input  wire logic [wfmw_pkg::COORD_W-1:0]       req_end_col,
   input  wire logic [wfmw_pkg::PIDX_W-1:0]        req_path_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_status,
   output logic      [wfmw_pkg::LEN_W-1:0]         rsp_move_count,
   output logic      [1:0]                         rsp_direction,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [wfmw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wfmw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wfmw_pkg::*;

   localparam int CW  = ($clog2(GRID_SIDE) > COORD_W) ? $clog2(GRID_SIDE) : COORD_W;
   localparam int AW  = $clog2(GRID_SIDE * GRID_SIDE);
   localparam int PAW = $clog2(PATH_DEPTH);

   // ---------------- configuration registers
   logic [GRID_W-1:0] grid_size_ff;
   logic [LEN_W-1:0]  move_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff  <= GRID_SIZE_RESET;
         move_limit_ff <= MOVE_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GRID_SIZE:  grid_size_ff  <= csr_wdata[GRID_W-1:0];
            REG_MOVE_LIMIT: move_limit_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- walk state
   state_type          state_ff, state_in;
   logic [CW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [COORD_W-1:0] erow_ff, erow_in;
   logic [COORD_W-1:0] ecol_ff, ecol_in;
   dir_type            head_ff, head_in;
   logic [1:0]         tries_ff, tries_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NSIZE_W-1:0] n_ff, n_in;
   logic               oob_ff;
   logic [LEN_W-1:0]   path_length_ff, path_length_in;
   logic               prd_ok_ff, prd_ok_in;

   // pending result, then the output register
   logic               res_status_ff, res_status_in;
   logic [LEN_W-1:0]   res_count_ff, res_count_in;
   dir_type            res_dir_ff, res_dir_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff;
   logic [LEN_W-1:0]   rsp_move_count_ff;
   dir_type            rsp_direction_ff;
   logic               rsp_load;

   // memories
   logic               cell_we;
   logic [AW-1:0]      cell_waddr;
   logic               cell_rdata;
   logic               path_we;
   dir_type            path_rdata;

   // neighbor probe
   dir_type            probe_dir;
   logic [CW-1:0]      nbr_row;
   logic [CW-1:0]      nbr_col;
   logic [AW-1:0]      nbr_addr;
   logic               nbr_oob;
   logic               blocked;
   logic               at_end;

   assign blocked = oob_ff | cell_rdata;
   assign at_end  = (row_ff == CW'(erow_ff)) && (col_ff == CW'(ecol_ff));
   assign cell_waddr = AW'(32'(req_row) * GRID_SIDE + 32'(req_col));

   // Probe direction per state: left of heading at the end check, the
   // heading itself after a blocked left, the next right turn while turning.
   always_comb begin
      case (state_ff)
         ST_END:  probe_dir = dir_type'(head_ff + 2'd1);
         ST_TRY:  probe_dir = dir_type'(head_ff + 2'd3);
         default: probe_dir = head_ff;
      endcase
   end

   wfmw_nbr #(.GRID_SIDE(GRID_SIDE)) u_nbr (
      .row  (row_ff),
      .col  (col_ff),
      .dir  (probe_dir),
      .n    (n_ff),
      .nrow (nbr_row),
      .ncol (nbr_col),
      .addr (nbr_addr),
      .oob  (nbr_oob)
   );

   wfmw_ram #(.WIDTH(1), .DEPTH(GRID_SIDE * GRID_SIDE)) u_cell_store (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (req_wall),
      .raddr (nbr_addr),
      .rdata (cell_rdata)
   );

   wfmw_ram #(.WIDTH(2), .DEPTH(PATH_DEPTH)) u_path_store (
      .clock (clock),
      .we    (path_we),
      .waddr (PAW'(count_ff)),
      .wdata (head_ff),
      .raddr (PAW'(req_path_index)),
      .rdata (path_rdata)
   );

   // ---------------- sequencer
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      erow_in        = erow_ff;
      ecol_in        = ecol_ff;
      head_in        = head_ff;
      tries_in       = tries_ff;
      count_in       = count_ff;
      n_in           = n_ff;
      path_length_in = path_length_ff;
      prd_ok_in      = prd_ok_ff;
      res_status_in  = res_status_ff;
      res_count_in   = res_count_ff;
      res_dir_in     = res_dir_ff;
      cell_we        = 1'b0;
      path_we        = 1'b0;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_status_in = 1'b0;
               res_count_in  = '0;
               res_dir_in    = DIR_N;
               case (req_mode)
                  MODE_WRITE: begin
                     cell_we  = (32'(req_row) < GRID_SIDE) && (32'(req_col) < GRID_SIDE);
                     state_in = ST_RESP;
                  end
                  MODE_WALK: begin
                     row_in   = CW'(req_row);
                     col_in   = CW'(req_col);
                     erow_in  = req_end_row;
                     ecol_in  = req_end_col;
                     count_in = '0;
                     n_in     = (32'(grid_size_ff) < GRID_SIDE) ?
                                NSIZE_W'(grid_size_ff) : NSIZE_W'(GRID_SIDE);
                     // start heading from the corner or edge of the start cell
                     if (req_row == '0) begin
                        head_in = (req_col == '0) ? DIR_E : DIR_S;
                     end else begin
                        head_in = (req_col == '0) ? DIR_N : DIR_W;
                     end
                     state_in = ST_END;
                  end
                  MODE_READ: begin
                     prd_ok_in = (req_path_index < path_length_ff) &&
                                 (32'(req_path_index) < PATH_DEPTH);
                     state_in  = ST_PREAD;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_PREAD: begin
            res_count_in = path_length_ff;
            res_dir_in   = prd_ok_ff ? path_rdata : DIR_N;
            state_in     = ST_RESP;
         end

         ST_END: begin
            if (count_ff > CNT_W'(move_limit_ff)) begin
               res_status_in  = 1'b1;
               res_count_in   = '0;
               path_length_in = '0;
               state_in       = ST_RESP;
            end else if (at_end) begin
               res_status_in  = 1'b0;
               res_count_in   = count_ff[LEN_W-1:0];
               path_length_in = count_ff[LEN_W-1:0];
               state_in       = ST_RESP;
            end else begin
               state_in = ST_LEFT;
            end
         end

         ST_LEFT: begin
            if (!blocked) begin
               head_in  = dir_type'(head_ff + 2'd1);
               state_in = ST_MOVE;
            end else begin
               tries_in = '0;
               state_in = ST_TRY;
            end
         end

         ST_TRY: begin
            if (!blocked) begin
               state_in = ST_MOVE;
            end else if (tries_ff == 2'd3) begin
               // trapped on all four sides
               res_status_in  = 1'b1;
               res_count_in   = '0;
               path_length_in = '0;
               state_in       = ST_RESP;
            end else begin
               head_in  = dir_type'(head_ff + 2'd3);
               tries_in = tries_ff + 2'd1;
            end
         end

         ST_MOVE: begin
            path_we  = (32'(count_ff) < PATH_DEPTH);
            row_in   = nbr_row;
            col_in   = nbr_col;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_END;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         path_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         path_length_ff <= path_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      erow_ff       <= erow_in;
      ecol_ff       <= ecol_in;
      head_ff       <= head_in;
      tries_ff      <= tries_in;
      count_ff      <= count_in;
      n_ff          <= n_in;
      oob_ff        <= nbr_oob;
      prd_ok_ff     <= prd_ok_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_dir_ff    <= res_dir_in;
      if (rsp_load) begin
         rsp_status_ff     <= res_status_ff;
         rsp_move_count_ff <= res_count_ff;
         rsp_direction_ff  <= res_dir_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_move_count = rsp_move_count_ff;
   assign rsp_direction  = rsp_direction_ff;

   // ---------------- assertions
   a_cell_write_on_request: assert property (@(posedge clock) disable iff (reset)
      cell_we |-> (req_valid && req_ready && (req_mode == MODE_WRITE)))
      else $error("cell store written without a write request");

   a_fail_zero_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && res_status_ff) |-> (res_count_ff == '0))
      else $error("failed walk reports a nonzero move count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END) |-> (count_ff <= CNT_W'(move_limit_ff) + CNT_W'(1)))
      else $error("walk ran past the move limit");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result issued outside the response state");

   a_path_write_in_move: assert property (@(posedge clock) disable iff (reset)
      path_we |-> ((state_ff == ST_MOVE) && !at_end))
      else $error("path store written outside a move");

endmodule

`default_nettype wire

// ===== sv/wfmw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfmw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== sv/wfmw_nbr.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Neighbor cell of (row, col) in direction dir: next coordinates, cell
// address, and whether it falls outside the grid in use.
module wfmw_nbr #(
   parameter int GRID_SIDE = 128,
   localparam int CW = ($clog2(GRID_SIDE) > wfmw_pkg::COORD_W) ?
                       $clog2(GRID_SIDE) : wfmw_pkg::COORD_W,
   localparam int AW = $clog2(GRID_SIDE * GRID_SIDE)
) (
   input  wire logic [CW-1:0]                row,
   input  wire logic [CW-1:0]                col,
   input  wire wfmw_pkg::dir_type            dir,
   input  wire logic [wfmw_pkg::NSIZE_W-1:0] n,
   output logic      [CW-1:0]                nrow,
   output logic      [CW-1:0]                ncol,
   output logic      [AW-1:0]                addr,
   output logic                              oob
);
   import wfmw_pkg::*;

   logic [CW:0] r_ext;
   logic [CW:0] c_ext;
   logic        under;

   always_comb begin
      r_ext = {1'b0, row};
      c_ext = {1'b0, col};
      under = 1'b0;
      case (dir)
         DIR_N: begin
            under = (row == '0);
            r_ext = {1'b0, row} - (CW+1)'(1);
         end
         DIR_S: r_ext = {1'b0, row} + (CW+1)'(1);
         DIR_W: begin
            under = (col == '0);
            c_ext = {1'b0, col} - (CW+1)'(1);
         end
         DIR_E: c_ext = {1'b0, col} + (CW+1)'(1);
         default: ;
      endcase
      oob  = under || (32'(r_ext) >= 32'(n)) || (32'(c_ext) >= 32'(n));
      nrow = r_ext[CW-1:0];
      ncol = c_ext[CW-1:0];
      addr = AW'(32'(r_ext[CW-1:0]) * GRID_SIDE + 32'(c_ext[CW-1:0]));
   end

endmodule

`default_nettype wire
